### design/mwc_pkg.sv
// Shared types, constants and step function for the multiply-with-carry generator.
// Used by mwc_controller, mwc_datapath and mwc_random_generator.
`default_nettype none

package mwc_pkg;

   // generator constants
   localparam logic [15:0] MUL_UP      = 16'd36969;
   localparam logic [15:0] MUL_LO      = 16'd18000;
   localparam logic [31:0] DEF_UP      = 32'hfc7d2ba2;
   localparam logic [31:0] DEF_LO      = 32'h534ffd12;
   localparam logic [31:0] SPLIT_UP    = 32'h55555555;
   localparam logic [31:0] SPLIT_LO    = 32'haaaaaaaa;
   localparam int          FRAC_W      = 23;
   localparam int          SPAN_W      = 33;
   localparam int          PROD_W      = FRAC_W + 32;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_SEED_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SEED_SECOND = 2'd1;
   localparam logic [1:0] CSR_SPLIT_MODE  = 2'd2;

   typedef enum logic [2:0] {
      KIND_RAW    = 3'd0,
      KIND_RANGED = 3'd1,
      KIND_UNIT   = 3'd2,
      KIND_SIGNED = 3'd3,
      KIND_RESEED = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_EMIT,
      ST_WARM1,
      ST_WARM2
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic advance;
      logic seed_load;
      logic capture;
      logic product;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

   // one multiply-with-carry step of a 16-bit value / 16-bit carry word
   function automatic logic [31:0] mwc_half_step(input logic [31:0] s, input logic [15:0] m);
      logic [31:0] prod;
      prod = {16'h0, m} * {16'h0, s[15:0]};
      return prod + {16'h0, s[31:16]};
   endfunction

endpackage

`default_nettype wire

### design/mwc_random_generator.sv
// Multiply-with-carry random generator: configuration registers and top-level wiring.
// Depends on mwc_pkg, mwc_controller and mwc_datapath.
//
// Usage:
//   Request channel (req_valid / req_stall) carries kind, range_low, range_high.
//   Kinds 0..3 draw one word and return one result on the rsp_ channel:
//   raw word, ranged integer, unit fraction, or signed fraction. Kind 4 reseeds
//   from the csr_ registers and returns nothing; kinds 5..7 are dropped.
//   Configuration is a write-only port (csr_write, csr_index, csr_data), to be
//   written only while the block is idle, by the user; the block does not enforce it.
// Sequence:
//   A draw: the transfer edge advances the state, the next cycle (ST_MULT) forms
//   the range product, and the result register loads from ST_EMIT once the output is free.
//   A new request is taken in the cycle the previous result is loaded, not
//   before, so a stalled output also holds off the next draw.
//   A split-mode reseed loads the seeds and then runs two warm-up steps
//   (ST_WARM1, ST_WARM2); a direct reseed only loads the seeds.
// Reset: state returns to its default words, seeds clear, split mode is set.
// A stalled result holds; one result is buffered, and a further draw waits.
`default_nettype none

module mwc_random_generator
   import mwc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [31:0] req_range_low,
   input  wire logic [31:0] req_range_high,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_value,
   output logic [FRAC_W-1:0] rsp_fraction,
   output logic             rsp_negative,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   logic [31:0] seed_first_ff;
   logic [31:0] seed_second_ff;
   logic        split_mode_ff;
   cmd_type     cmd;
   status_type  status;

   // configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_first_ff  <= 32'h0;
         seed_second_ff <= 32'h0;
         split_mode_ff  <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SEED_FIRST:  seed_first_ff  <= csr_data;
            CSR_SEED_SECOND: seed_second_ff <= csr_data;
            CSR_SPLIT_MODE:  split_mode_ff  <= csr_data[0];
            default:         split_mode_ff  <= split_mode_ff;
         endcase
      end
   end

   mwc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_kind   (req_kind),
      .split_mode (split_mode_ff),
      .status     (status),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   mwc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_kind),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .seed_first     (seed_first_ff),
      .seed_second    (seed_second_ff),
      .split_mode     (split_mode_ff),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value),
      .rsp_fraction   (rsp_fraction),
      .rsp_negative   (rsp_negative)
   );

endmodule

`default_nettype wire

### design/mwc_controller.sv
// Sequencer for the multiply-with-carry generator: accept, multiply, emit, warm-up.
// Depends on mwc_pkg; drives the command struct of mwc_datapath.
`default_nettype none

module mwc_controller
   import mwc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [2:0] req_kind,
   input  wire logic       split_mode,
   input  wire status_type status,
   output logic            req_stall,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;
   state_type after_accept;
   logic      open;
   logic      accept;
   logic      is_draw;
   logic      is_reseed;
   kind_type  kind;

   assign kind      = kind_type'(req_kind);
   assign is_draw   = (kind == KIND_RAW) || (kind == KIND_RANGED) ||
                      (kind == KIND_UNIT) || (kind == KIND_SIGNED);
   assign is_reseed = (kind == KIND_RESEED);

   // take a request when idle, or in the cycle the previous result leaves
   assign open      = (state_ff == ST_IDLE) || ((state_ff == ST_EMIT) && status.out_free);
   assign req_stall = !open;
   assign accept    = req_valid && open;

   // state that follows a transfer on the request side
   always_comb begin
      after_accept = ST_IDLE;
      if (accept && is_draw) begin
         after_accept = ST_MULT;
      end else if (accept && is_reseed && split_mode) begin
         after_accept = ST_WARM1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  state_in = after_accept;
         ST_MULT:  state_in = ST_EMIT;
         ST_EMIT:  state_in = status.out_free ? after_accept : ST_EMIT;
         ST_WARM1: state_in = ST_WARM2;
         ST_WARM2: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_MULT:  cmd.product = 1'b1;
         ST_EMIT:  cmd.emit    = status.out_free;
         ST_WARM1: cmd.advance = 1'b1;
         ST_WARM2: cmd.advance = 1'b1;
         default:  cmd = '0;
      endcase
      if (accept && is_draw) begin
         cmd.advance = 1'b1;
         cmd.capture = 1'b1;
      end
      if (accept && is_reseed) begin
         cmd.seed_load = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a draw always runs its multiply cycle next
   a_draw_to_mult: assert property (@(posedge clock) disable iff (reset)
      (accept && is_draw) |=> (state_ff == ST_MULT))
      else $error("draw not followed by multiply");

   // warm-up is exactly two steps
   a_warm_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WARM1) |=> (state_ff == ST_WARM2 && cmd.advance))
      else $error("warm-up sequence broken");

   // never advance and load the state at once
   a_state_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.advance, cmd.seed_load}))
      else $error("conflicting state commands");

endmodule

`default_nettype wire

### design/mwc_datapath.sv
// Generator state, range multiply and result register of the multiply-with-carry generator.
// Depends on mwc_pkg; commanded by mwc_controller.
`default_nettype none

module mwc_datapath
   import mwc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic [2:0]  req_kind,
   input  wire logic [31:0] req_range_low,
   input  wire logic [31:0] req_range_high,
   input  wire logic [31:0] seed_first,
   input  wire logic [31:0] seed_second,
   input  wire logic        split_mode,
   input  wire logic        rsp_stall,
   output status_type       status,
   output logic             rsp_valid,
   output logic [31:0]      rsp_value,
   output logic [FRAC_W-1:0] rsp_fraction,
   output logic             rsp_negative
);

   logic [31:0]       upper_ff, upper_in;
   logic [31:0]       lower_ff, lower_in;
   kind_type          kind_ff;
   logic [31:0]       low_ff;
   logic [SPAN_W-1:0] span_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              rsp_valid_ff;
   logic [31:0]       word;
   logic [31:0]       seed_up;
   logic [31:0]       seed_lo;
   logic [31:0]       value_in;

   // current 32-bit output word
   assign word = {upper_ff[15:0], lower_ff[15:0]};

   // zero seeds fall back to the defaults
   assign seed_up = (seed_first  != 32'h0) ? seed_first  : DEF_UP;
   assign seed_lo = (seed_second != 32'h0) ? seed_second : DEF_LO;

   // generator state: advance, reseed or hold
   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (cmd.advance) begin
         upper_in = mwc_half_step(upper_ff, MUL_UP);
         lower_in = mwc_half_step(lower_ff, MUL_LO);
      end else if (cmd.seed_load) begin
         if (split_mode) begin
            upper_in = seed_up & SPLIT_UP;
            lower_in = seed_up & SPLIT_LO;
         end else begin
            upper_in = seed_up;
            lower_in = seed_lo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= DEF_UP;
         lower_ff <= DEF_LO;
      end else begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
      end
   end

   // capture request operands; span is held in 33 bits so the full range is 2^32
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_kind);
         low_ff  <= req_range_low;
         span_ff <= {1'b0, req_range_high - req_range_low} + SPAN_W'(1);
      end
   end

   // scale the fraction by the span; bit 32 of the span only occurs alone
   always_ff @(posedge clock) begin
      if (cmd.product) begin
         if (span_ff[SPAN_W-1]) begin
            prod_ff <= {word[FRAC_W-1:0], 32'h0};
         end else begin
            prod_ff <= {{(PROD_W-32){1'b0}}, span_ff[31:0]} *
                       {{(PROD_W-FRAC_W){1'b0}}, word[FRAC_W-1:0]};
         end
      end
   end

   // select the result value by kind
   always_comb begin
      case (kind_ff)
         KIND_RAW:    value_in = word;
         KIND_RANGED: value_in = low_ff + prod_ff[PROD_W-1:FRAC_W];
         default:     value_in = 32'h0;
      endcase
   end

   // result register: load on emit, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value    <= value_in;
         rsp_fraction <= word[FRAC_W-1:0];
         rsp_negative <= (kind_ff == KIND_SIGNED) ? word[31] : 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // an emitted result is always presented next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

   // full-range span yields a product with a clear low word
   a_full_span: assert property (@(posedge clock) disable iff (reset)
      (cmd.product && span_ff[SPAN_W-1]) |=> (prod_ff[31:0] == 32'h0))
      else $error("full-range product malformed");

   // a direct reseed never leaves a zero upper or lower state
   a_seed_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.seed_load && !split_mode) |=> (upper_ff != 32'h0 && lower_ff != 32'h0))
      else $error("direct reseed loaded zero state");

endmodule

`default_nettype wire
